// File: src/rtog_pkg.sv
// Shared types and constants for the rectangle table overlap guard.
`timescale 1ns / 1ps
package rtog_pkg;

   localparam int DefaultTableDepth = 16;
   localparam int MaxResults        = 16;
   localparam int MatchW            = $clog2(MaxResults + 1);
   localparam int CoordW            = 16;
   localparam int AreaW             = 32;
   localparam int SumW              = 37;
   localparam int TotalW            = 36;
   localparam int RemovedW          = 5;

   localparam logic [1:0] OpInsert = 2'd0;
   localparam logic [1:0] OpRemove = 2'd1;
   localparam logic [1:0] OpQuery  = 2'd2;
   localparam logic [1:0] OpReport = 2'd3;

   typedef struct packed {
      logic              valid;
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [CoordW-1:0] w;
      logic [CoordW-1:0] h;
   } slot_type;

endpackage

// File: src/rtog_req_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface rtog_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] pos_x;
   logic [15:0] pos_y;
   logic [15:0] size_w;
   logic [15:0] size_h;
   logic [31:0] area_limit;

   modport source (output valid, opcode, pos_x, pos_y, size_w, size_h, area_limit,
                   input ready);
   modport sink   (input valid, opcode, pos_x, pos_y, size_w, size_h, area_limit,
                   output ready);
endinterface

interface rtog_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        accepted;
   logic        match_found;
   logic [15:0] hit_x;
   logic [15:0] hit_y;
   logic [15:0] hit_w;
   logic [15:0] hit_h;
   logic [4:0]  removed_count;
   logic [35:0] total_area;
   logic        last;

   modport source (output valid, kind, accepted, match_found, hit_x, hit_y, hit_w, hit_h,
                   removed_count, total_area, last, input ready);
   modport sink   (input valid, kind, accepted, match_found, hit_x, hit_y, hit_w, hit_h,
                   removed_count, total_area, last, output ready);
endinterface

// File: src/rectangle_table_overlap_guard.sv
// Top level: rotating slot chain with a scan controller at its head cell.
// Sequence: a request is taken in IDLE, the ring rotates once past all TABLE_DEPTH slots in
//   SCAN, then FINISH emits the final beat; a new request is taken only back in IDLE.
// Flow: query results stall the rotation, and FINISH waits, while the output register
//   is still held by the sink.
// Reset: synchronous, active high; clears all slot valid bits, the area sum and control.
`timescale 1ns / 1ps
module rectangle_table_overlap_guard #(
   parameter int TABLE_DEPTH = rtog_pkg::DefaultTableDepth
) (
   input  logic       clock,
   input  logic       reset,
   rtog_req_if.sink   req_bus,
   rtog_rsp_if.source rsp_bus
);
   localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntW = $clog2(TABLE_DEPTH + 1);

   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StScan   = 2'd1;
   localparam logic [1:0] StFinish = 2'd2;

   typedef struct packed {
      logic [1:0]                    kind;
      logic                          accepted;
      logic                          match_found;
      rtog_pkg::slot_type            hit;
      logic [rtog_pkg::RemovedW-1:0] removed_count;
      logic [rtog_pkg::TotalW-1:0]   total_area;
      logic                          last;
   } rsp_type;

   function automatic logic [rtog_pkg::TotalW-1:0] sat_total(
      input logic [rtog_pkg::SumW-1:0] s);
      sat_total = s[rtog_pkg::SumW-1] ? '1 : s[rtog_pkg::TotalW-1:0];
   endfunction

   // control state
   logic [1:0]                  state_ff, state_in;
   logic [CntW-1:0]             cnt_ff, cnt_in;
   logic                        hit_ff, hit_in;
   logic                        free_ok_ff, free_ok_in;
   logic [IdxW-1:0]             free_idx_ff, free_idx_in;
   logic [CntW-1:0]             removed_ff, removed_in;
   logic [rtog_pkg::MatchW-1:0] matches_ff, matches_in;
   logic                        pend_valid_ff, pend_valid_in;
   rtog_pkg::slot_type          pend_ff, pend_in;
   logic [rtog_pkg::SumW-1:0]   sum_ff, sum_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_ff, rsp_in;

   // latched command
   logic [1:0]                  op_ff, op_in;
   rtog_pkg::slot_type          cmd_ff, cmd_in;
   logic [31:0]                 limit_ff, limit_in;
   logic [rtog_pkg::AreaW-1:0]  cmd_area_ff, cmd_area_in;

   rtog_pkg::slot_type          slots [TABLE_DEPTH];
   rtog_pkg::slot_type          head, tail_in;
   logic                        shift_en;
   logic [TABLE_DEPTH-1:0]      wr_en;

   logic                        req_take, out_free;
   logic [16:0]                 px1, py1, hx1, hy1;
   logic                        meets, is_match, q_take, rm_hit, advance;
   logic [rtog_pkg::AreaW-1:0]  head_area;
   logic                        any_valid;

   assign head     = slots[0];
   assign req_take = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   assign px1 = {1'b0, cmd_ff.x} + {1'b0, cmd_ff.w};
   assign py1 = {1'b0, cmd_ff.y} + {1'b0, cmd_ff.h};
   assign hx1 = {1'b0, head.x} + {1'b0, head.w};
   assign hy1 = {1'b0, head.y} + {1'b0, head.h};

   // closed-box test: touching edges and corners count as overlap
   assign meets = head.valid && ({1'b0, cmd_ff.x} <= hx1) && ({1'b0, head.x} <= px1)
                  && ({1'b0, cmd_ff.y} <= hy1) && ({1'b0, head.y} <= py1);

   assign head_area = head.w * head.h;
   assign rm_hit    = (op_ff == rtog_pkg::OpRemove) && head.valid
                      && (head_area > limit_ff);
   assign is_match  = head.valid && (head.x == cmd_ff.x) && (head.y == cmd_ff.y);
   assign q_take    = (op_ff == rtog_pkg::OpQuery) && is_match
                      && (32'(matches_ff) < 32'(rtog_pkg::MaxResults));

   // stall the ring when a second match needs the output register and it is busy
   assign advance  = (state_ff == StScan) && !(q_take && pend_valid_ff && !out_free);
   assign shift_en = advance;

   always_comb begin
      tail_in = head;
      tail_in.valid = head.valid && !rm_hit;
   end

   assign req_bus.ready = (state_ff == StIdle);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      hit_in        = hit_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      removed_in    = removed_ff;
      matches_in    = matches_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_in        = rsp_ff;
      op_in         = op_ff;
      cmd_in        = cmd_ff;
      limit_in      = limit_ff;
      cmd_area_in   = cmd_area_ff;
      wr_en         = '0;

      unique case (state_ff)
         StIdle: begin
            if (req_take) begin
               op_in         = req_bus.opcode;
               cmd_in.valid  = 1'b1;
               cmd_in.x      = req_bus.pos_x;
               cmd_in.y      = req_bus.pos_y;
               cmd_in.w      = req_bus.size_w;
               cmd_in.h      = req_bus.size_h;
               limit_in      = req_bus.area_limit;
               cmd_area_in   = req_bus.size_w * req_bus.size_h;
               cnt_in        = '0;
               hit_in        = 1'b0;
               free_ok_in    = 1'b0;
               free_idx_in   = '0;
               removed_in    = '0;
               matches_in    = '0;
               pend_valid_in = 1'b0;
               state_in      = StScan;
            end
         end
         StScan: begin
            if (advance) begin
               if (meets) begin
                  hit_in = 1'b1;
               end
               if (!head.valid && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = cnt_ff[IdxW-1:0];
               end
               if (rm_hit) begin
                  sum_in     = sum_ff - {{(rtog_pkg::SumW-rtog_pkg::AreaW){1'b0}}, head_area};
                  removed_in = removed_ff + 1'b1;
               end
               if (q_take) begin
                  // push the held match out; it is not the last one
                  if (pend_valid_ff) begin
                     rsp_valid_in         = 1'b1;
                     rsp_in               = '0;
                     rsp_in.kind          = rtog_pkg::OpQuery;
                     rsp_in.match_found   = 1'b1;
                     rsp_in.hit           = pend_ff;
                     rsp_in.total_area    = sat_total(sum_ff);
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = head;
                  matches_in    = matches_ff + 1'b1;
               end
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CntW'(TABLE_DEPTH - 1)) begin
                  state_in = StFinish;
               end
            end
         end
         StFinish: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = '0;
               rsp_in.kind   = op_ff;
               rsp_in.last   = 1'b1;
               rsp_in.total_area = sat_total(sum_ff);
               unique case (op_ff)
                  rtog_pkg::OpInsert: begin
                     if (!hit_ff && free_ok_ff) begin
                        wr_en[free_idx_ff] = 1'b1;
                        sum_in = sum_ff + {{(rtog_pkg::SumW-rtog_pkg::AreaW){1'b0}},
                                           cmd_area_ff};
                        rsp_in.accepted   = 1'b1;
                        rsp_in.total_area = sat_total(sum_in);
                     end
                  end
                  rtog_pkg::OpRemove: begin
                     rsp_in.removed_count = (removed_ff > CntW'(31)) ? 5'd31
                                            : rtog_pkg::RemovedW'(removed_ff);
                  end
                  rtog_pkg::OpQuery: begin
                     if (pend_valid_ff) begin
                        rsp_in.match_found = 1'b1;
                        rsp_in.hit         = pend_ff;
                     end
                  end
                  default: begin
                  end
               endcase
               pend_valid_in = 1'b0;
               state_in      = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         cnt_ff        <= '0;
         hit_ff        <= 1'b0;
         free_ok_ff    <= 1'b0;
         removed_ff    <= '0;
         matches_ff    <= '0;
         pend_valid_ff <= 1'b0;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         hit_ff        <= hit_in;
         free_ok_ff    <= free_ok_in;
         removed_ff    <= removed_in;
         matches_ff    <= matches_in;
         pend_valid_ff <= pend_valid_in;
         sum_ff        <= sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      free_idx_ff <= free_idx_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      op_ff       <= op_in;
      cmd_ff      <= cmd_in;
      limit_ff    <= limit_in;
      cmd_area_ff <= cmd_area_in;
   end

   // slot ring: head hands its entry to the tail, every other cell to its lower neighbor
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      rtog_pkg::slot_type nb;
      if (i == TABLE_DEPTH - 1) begin : g_tail
         assign nb = tail_in;
      end else begin : g_mid
         assign nb = slots[i+1];
      end
      rtog_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .shift_in (nb),
         .wr_en    (wr_en[i]),
         .wr_data  (cmd_ff),
         .slot     (slots[i])
      );
   end

   always_comb begin
      any_valid = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         any_valid = any_valid | slots[i].valid;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.kind          = rsp_ff.kind;
   assign rsp_bus.accepted      = rsp_ff.accepted;
   assign rsp_bus.match_found   = rsp_ff.match_found;
   assign rsp_bus.hit_x         = rsp_ff.hit.x;
   assign rsp_bus.hit_y         = rsp_ff.hit.y;
   assign rsp_bus.hit_w         = rsp_ff.hit.w;
   assign rsp_bus.hit_h         = rsp_ff.hit.h;
   assign rsp_bus.removed_count = rsp_ff.removed_count;
   assign rsp_bus.total_area    = rsp_ff.total_area;
   assign rsp_bus.last          = rsp_ff.last;

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StScan) |-> (32'(cnt_ff) < TABLE_DEPTH))
      else $error("scan counter ran past the table");

   a_pend_query: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (op_ff == rtog_pkg::OpQuery))
      else $error("held match outside a query");

   a_finish_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StFinish && out_free) |=> (rsp_valid_ff && rsp_ff.last))
      else $error("finish cycle gave no final beat");

   a_empty_sum: assert property (@(posedge clock) disable iff (reset)
      (state_ff == StIdle && !any_valid) |-> (sum_ff == '0))
      else $error("area sum nonzero with empty table");
endmodule

// File: src/rtog_cell.sv
// One table slot; shifts toward its neighbor during a scan, written in place on insert.
`timescale 1ns / 1ps
module rtog_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  rtog_pkg::slot_type shift_in,
   input  logic              wr_en,
   input  rtog_pkg::slot_type wr_data,
   output rtog_pkg::slot_type slot
);
   rtog_pkg::slot_type slot_ff, slot_in;

   always_comb begin
      slot_in = slot_ff;
      if (wr_en) begin
         slot_in = wr_data;
      end else if (shift_en) begin
         slot_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.x <= slot_in.x;
      slot_ff.y <= slot_in.y;
      slot_ff.w <= slot_in.w;
      slot_ff.h <= slot_in.h;
   end

   assign slot = slot_ff;
endmodule

// File: bench/rectangle_table_overlap_guard_test.sv
// Self-checking bench for the rectangle table: inserts, removals, queries and totals.
`timescale 1ns / 1ps
module rectangle_table_overlap_guard_test;

   localparam int Depth      = rtog_pkg::DefaultTableDepth;
   localparam int CycleLimit = 400000;

   // One request beat and one response beat, at the block's widths.
   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] size_w;
      logic [15:0] size_h;
      logic [31:0] area_limit;
   } request_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        accepted;
      logic        match_found;
      logic [15:0] hit_x;
      logic [15:0] hit_y;
      logic [15:0] hit_w;
      logic [15:0] hit_h;
      logic [4:0]  removed_count;
      logic [35:0] total_area;
      logic        last;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rtog_req_if req_bus ();
   rtog_rsp_if rsp_bus ();

   rectangle_table_overlap_guard #(.TABLE_DEPTH(Depth)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   always #10 clock = ~clock;

   // Shadow copy of the rectangle table.
   logic [15:0] tbl_x [Depth];
   logic [15:0] tbl_y [Depth];
   logic [15:0] tbl_w [Depth];
   logic [15:0] tbl_h [Depth];
   logic        tbl_used [Depth];
   logic [36:0] tbl_area;

   request_type  pending_reqs [$];
   response_type expected_rsps [$];

   int  errors;
   int  cycle_count;
   int  sent_count;
   int  rsp_count;
   int  accept_count;
   int  hit_count;
   bit  quiet_stretch;   // suppress random idling on both sides
   int  hold_off;        // cycles the receiver refuses responses
   bit  hold_started;
   bit  req_fire;

   function automatic logic [35:0] clipped_total();
      return (tbl_area > 37'hF_FFFF_FFFF) ? 36'hF_FFFF_FFFF : tbl_area[35:0];
   endfunction

   function automatic response_type blank_rsp(logic [1:0] kind);
      response_type r;
      r = '0;
      r.kind = kind;
      r.total_area = clipped_total();
      r.last = 1'b1;
      return r;
   endfunction

   task automatic add_request(request_type q);
      pending_reqs.insert(pending_reqs.size(), q);
   endtask

   task automatic add_expected(response_type r);
      expected_rsps.insert(expected_rsps.size(), r);
   endtask

   // Closed-box overlap; bounds at 17 bits so they never wrap.
   function automatic bit boxes_touch(request_type q, int i);
      logic [16:0] ax1, ay1, bx1, by1;
      ax1 = {1'b0, q.pos_x} + {1'b0, q.size_w};
      ay1 = {1'b0, q.pos_y} + {1'b0, q.size_h};
      bx1 = {1'b0, tbl_x[i]} + {1'b0, tbl_w[i]};
      by1 = {1'b0, tbl_y[i]} + {1'b0, tbl_h[i]};
      return ({1'b0, q.pos_x} <= bx1) && ({1'b0, tbl_x[i]} <= ax1)
             && ({1'b0, q.pos_y} <= by1) && ({1'b0, tbl_y[i]} <= ay1);
   endfunction

   // Apply one accepted request to the shadow table and queue its responses.
   task automatic predict_table_op(request_type q);
      response_type r;
      bit        overlap;
      int        free_idx;
      int        match_cnt;
      int        removed;
      logic [31:0] area;
      unique case (q.opcode)
         rtog_pkg::OpInsert: begin
            overlap  = 0;
            free_idx = -1;
            for (int i = 0; i < Depth; i++) begin
               if (tbl_used[i]) begin
                  if (boxes_touch(q, i)) overlap = 1;
               end else if (free_idx < 0) begin
                  free_idx = i;
               end
            end
            if (!overlap && free_idx >= 0) begin
               tbl_x[free_idx]    = q.pos_x;
               tbl_y[free_idx]    = q.pos_y;
               tbl_w[free_idx]    = q.size_w;
               tbl_h[free_idx]    = q.size_h;
               tbl_used[free_idx] = 1'b1;
               area = {16'd0, q.size_w} * {16'd0, q.size_h};
               tbl_area = tbl_area + {5'd0, area};
            end
            r = blank_rsp(rtog_pkg::OpInsert);
            r.accepted = !overlap && free_idx >= 0;
            add_expected(r);
         end
         rtog_pkg::OpRemove: begin
            removed = 0;
            for (int i = 0; i < Depth; i++) begin
               area = {16'd0, tbl_w[i]} * {16'd0, tbl_h[i]};
               if (tbl_used[i] && area > q.area_limit) begin
                  tbl_used[i] = 1'b0;
                  tbl_area = tbl_area - {5'd0, area};
                  removed++;
               end
            end
            r = blank_rsp(rtog_pkg::OpRemove);
            r.removed_count = (removed > 31) ? 5'd31 : removed[4:0];
            add_expected(r);
         end
         rtog_pkg::OpQuery: begin
            match_cnt = 0;
            for (int i = 0; i < Depth && match_cnt < rtog_pkg::MaxResults; i++) begin
               if (tbl_used[i] && tbl_x[i] == q.pos_x && tbl_y[i] == q.pos_y) begin
                  r = blank_rsp(rtog_pkg::OpQuery);
                  r.last = 1'b0;
                  r.match_found = 1'b1;
                  r.hit_x = tbl_x[i];
                  r.hit_y = tbl_y[i];
                  r.hit_w = tbl_w[i];
                  r.hit_h = tbl_h[i];
                  add_expected(r);
                  match_cnt++;
               end
            end
            if (match_cnt == 0) add_expected(blank_rsp(rtog_pkg::OpQuery));
            else expected_rsps[$].last = 1'b1;
         end
         default: add_expected(blank_rsp(rtog_pkg::OpReport));
      endcase
   endtask

   task automatic report_mismatch(response_type got, response_type want);
      $display("mismatch at response %0d: got %h expected %h", rsp_count, got, want);
      errors++;
   endtask

   function automatic request_type make_req(logic [1:0] op, int x, int y, int w, int h,
                                            logic [31:0] lim);
      request_type q;
      q.opcode = op;
      q.pos_x = 16'(x); q.pos_y = 16'(y); q.size_w = 16'(w); q.size_h = 16'(h);
      q.area_limit = lim;
      return q;
   endfunction

   // Coordinates on a coarse grid so inserts often fit, collide, touch and repeat anchors.
   function automatic request_type random_req();
      request_type q;
      int sel;
      q.opcode = 2'($urandom_range(0, 3));
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         q.pos_x = 16'($urandom); q.pos_y = 16'($urandom);
         q.size_w = 16'($urandom); q.size_h = 16'($urandom);
      end else begin
         q.pos_x  = 16'($urandom_range(0, 15) * 4096
                        + $urandom_range(0, 1) * $urandom_range(0, 4095));
         q.pos_y  = 16'($urandom_range(0, 15) * 4096
                        + $urandom_range(0, 1) * $urandom_range(0, 4095));
         q.size_w = 16'($urandom_range(0, 4) == 0 ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 4095));
         q.size_h = 16'($urandom_range(0, 4) == 0 ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 4095));
      end
      case ($urandom_range(0, 3))
         0: q.area_limit = $urandom;
         1: q.area_limit = $urandom_range(0, 16777215);
         2: q.area_limit = 32'hFFFF_FFFF - $urandom_range(0, 1000);
         default: q.area_limit = $urandom_range(0, 4000) * $urandom_range(0, 4000);
      endcase
      return q;
   endfunction

   // Take the accepted beat off the pending queue and predict its responses.
   always @(posedge clock) begin
      request_type q;
      req_fire <= !reset && req_bus.valid && req_bus.ready;
      if (!reset && req_bus.valid && req_bus.ready) begin
         q = pending_reqs.pop_front();
         predict_table_op(q);
         sent_count++;
      end
   end

   // Driver: change inputs at the falling edge; hold a beat that still waits for ready.
   always @(negedge clock) begin
      request_type q;
      bit offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         offer = (pending_reqs.size() > 0) && (quiet_stretch || $urandom_range(0, 99) >= 7);
         q = (pending_reqs.size() > 0) ? pending_reqs[0] : '0;
         req_bus.valid      <= offer;
         req_bus.opcode     <= q.opcode;
         req_bus.pos_x      <= q.pos_x;
         req_bus.pos_y      <= q.pos_y;
         req_bus.size_w     <= q.size_w;
         req_bus.size_h     <= q.size_h;
         req_bus.area_limit <= q.area_limit;
      end
   end

   // Receiver ready: random stalls, plus one long hold-off counted here.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (!hold_started && sent_count >= 140) begin
         rsp_bus.ready <= 1'b0;
         hold_started  <= 1'b1;
         hold_off      <= 300;
      end else if (hold_off > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else begin
         rsp_bus.ready <= quiet_stretch || $urandom_range(0, 99) >= 7;
      end
   end

   // Monitor: compare every response beat with the oldest expectation.
   always @(posedge clock) begin
      response_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.kind, rsp_bus.accepted, rsp_bus.match_found, rsp_bus.hit_x,
                 rsp_bus.hit_y, rsp_bus.hit_w, rsp_bus.hit_h, rsp_bus.removed_count,
                 rsp_bus.total_area, rsp_bus.last};
         if (expected_rsps.size() == 0) begin
            report_mismatch(got, '0);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) report_mismatch(got, want);
            if (want.accepted) accept_count++;
            if (want.match_found) hit_count++;
         end
         rsp_count++;
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      request_type q;
      errors = 0; cycle_count = 0; sent_count = 0; rsp_count = 0;
      accept_count = 0; hit_count = 0; quiet_stretch = 1'b0; hold_off = 0;
      hold_started = 1'b0;
      tbl_area = '0;
      for (int i = 0; i < Depth; i++) begin
         tbl_used[i] = 1'b0; tbl_x[i] = '0; tbl_y[i] = '0; tbl_w[i] = '0; tbl_h[i] = '0;
      end
      req_bus.valid = 1'b0; req_bus.opcode = rtog_pkg::OpReport;
      req_bus.pos_x = '0; req_bus.pos_y = '0;
      req_bus.size_w = '0; req_bus.size_h = '0; req_bus.area_limit = '0;
      rsp_bus.ready = 1'b0;

      // Directed part: empty query, extremes, touching edge and corner, containment,
      // zero-size boxes, full table, removal at the limit and report.
      add_request(make_req(rtog_pkg::OpQuery, 0, 0, 0, 0, 0));
      add_request(make_req(rtog_pkg::OpInsert, 65535, 65535, 65535, 65535, 0));
      add_request(make_req(rtog_pkg::OpInsert, 0, 0, 100, 100, 0));
      add_request(make_req(rtog_pkg::OpInsert, 100, 0, 5, 5, 0));      // shares an edge
      add_request(make_req(rtog_pkg::OpInsert, 101, 101, 5, 5, 0));    // one step clear
      add_request(make_req(rtog_pkg::OpInsert, 106, 106, 0, 0, 0));    // corner point touch
      add_request(make_req(rtog_pkg::OpInsert, 10, 10, 3, 3, 0));      // inside another
      add_request(make_req(rtog_pkg::OpInsert, 1000, 1000, 0, 50, 0)); // zero width
      add_request(make_req(rtog_pkg::OpInsert, 990, 990, 100, 100, 0)); // holds another
      add_request(make_req(rtog_pkg::OpQuery, 65535, 65535, 0, 0, 0));
      add_request(make_req(rtog_pkg::OpReport, 0, 0, 0, 0, 32'hFFFF_FFFF));
      add_request(make_req(rtog_pkg::OpRemove, 0, 0, 0, 0, 32'hFFFE_0001)); // equal: kept
      add_request(make_req(rtog_pkg::OpRemove, 0, 0, 0, 0, 32'hFFFE_0000));
      for (int i = 0; i < 13; i++)
         add_request(make_req(rtog_pkg::OpInsert, 2000 + i * 3000, 40000, i, 1, 0));
      add_request(make_req(rtog_pkg::OpInsert, 60000, 1, 1, 1, 0));    // table full
      add_request(make_req(rtog_pkg::OpRemove, 0, 0, 0, 0, 0));
      add_request(make_req(rtog_pkg::OpRemove, 0, 0, 0, 0, 32'hFFFF_FFFF));

      // Random part; inserts of identical zero-size anchors are overlaps, so repeated
      // anchors only appear via the random grid.
      for (int i = 0; i < 332; i++) begin
         q = random_req();
         add_request(q);
      end

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // A long clean stretch; the receiver then holds off while requests keep coming.
      wait (sent_count >= 60);
      @(negedge clock) quiet_stretch <= 1'b1;
      wait (sent_count >= 140);
      @(negedge clock) quiet_stretch <= 1'b0;

      wait (pending_reqs.size() == 0);
      wait (expected_rsps.size() == 0);
      repeat (40) @(posedge clock);

      $display("covered %0d requests, %0d response beats, %0d stored inserts, %0d query hits",
               sent_count, rsp_count, accept_count, hit_count);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("errors: %0d", errors);
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
